@@ design/cid_pkg.sv @@
// Shared types, constants and key table for the card ID descrambler.
`default_nettype none

package cid_pkg;

  localparam logic [7:0]  CHK_SEED_RAW = 8'hC9;
  localparam logic [7:0]  CHK_SEED_DEC = 8'hE2;
  localparam logic [15:0] UC_FLAG      = 16'h8000;
  localparam logic [15:0] UC_KEEP_MASK = 16'h7FFF;
  localparam logic [15:0] UC_XOR       = 16'h6A29;
  localparam logic [31:0] ID_XOR       = 32'h0000B2A6;

  typedef enum logic [1:0] {
    PATH_DESCRAMBLED = 2'd0,
    PATH_RAW         = 2'd1,
    PATH_RAW_MASKED  = 2'd2
  } decode_path_t;

  typedef struct packed {
    logic [15:0]  user_code;
    logic [31:0]  card_id;
    decode_path_t decode_path;
  } cid_result_t;

  localparam logic [7:0] KEY_ROM [256] = '{
    8'hf4, 8'h41, 8'h17, 8'h27, 8'hab, 8'h9d, 8'hfa, 8'he3,
    8'h30, 8'h76, 8'hcc, 8'h02, 8'he5, 8'h2a, 8'h35, 8'h62,
    8'hb1, 8'hba, 8'hea, 8'hfe, 8'h2f, 8'h4c, 8'h46, 8'hd3,
    8'h8f, 8'h92, 8'h6d, 8'h52, 8'hbe, 8'h74, 8'he0, 8'hc9,
    8'hc2, 8'h8e, 8'h58, 8'hb9, 8'he1, 8'h88, 8'h20, 8'hce,
    8'hdf, 8'h1a, 8'h51, 8'h53, 8'h7c, 8'h42, 8'h84, 8'h00,
    8'h64, 8'h6b, 8'h81, 8'h08, 8'ha4, 8'h3f, 8'ha5, 8'ha2,
    8'h48, 8'h45, 8'hde, 8'h7b, 8'h73, 8'h4b, 8'h1f, 8'h55,
    8'heb, 8'hb5, 8'hc5, 8'h37, 8'h28, 8'hbf, 8'h03, 8'h16,
    8'hcf, 8'h79, 8'h07, 8'h69, 8'hda, 8'h05, 8'h34, 8'ha6,
    8'h2e, 8'hf3, 8'h8a, 8'hf6, 8'h83, 8'h60, 8'h71, 8'h6e,
    8'h21, 8'hdd, 8'h3e, 8'he6, 8'h54, 8'hc4, 8'h06, 8'h50,
    8'h98, 8'hbd, 8'h40, 8'hd9, 8'he8, 8'h89, 8'h19, 8'hc8,
    8'h80, 8'h2b, 8'h11, 8'h5a, 8'h0e, 8'h85, 8'hae, 8'h2d,
    8'h0f, 8'h5c, 8'h5b, 8'h36, 8'h0a, 8'h57, 8'hee, 8'h9b,
    8'hc0, 8'hdc, 8'h77, 8'h12, 8'h93, 8'ha0, 8'h22, 8'h1b,
    8'h09, 8'h8b, 8'hb6, 8'h1e, 8'hf1, 8'h75, 8'h99, 8'h7f,
    8'h43, 8'h23, 8'hed, 8'he4, 8'h01, 8'h72, 8'h66, 8'hfb,
    8'h31, 8'h63, 8'h97, 8'hc6, 8'h4a, 8'hbb, 8'hf9, 8'h29,
    8'h9e, 8'hb2, 8'h86, 8'hc1, 8'hb3, 8'h70, 8'h94, 8'he9,
    8'hfc, 8'hf0, 8'h7d, 8'h33, 8'h49, 8'h38, 8'hca, 8'hd4,
    8'h3a, 8'h78, 8'h5f, 8'h7e, 8'hf5, 8'h7a, 8'hb7, 8'had,
    8'h8d, 8'hd8, 8'h39, 8'hc3, 8'h5d, 8'hd0, 8'hd5, 8'h25,
    8'hac, 8'h18, 8'h9c, 8'h3b, 8'h26, 8'h59, 8'h9a, 8'h4f,
    8'h95, 8'hff, 8'hbc, 8'h15, 8'he7, 8'h6f, 8'h9f, 8'hb0,
    8'h4e, 8'h82, 8'h90, 8'ha7, 8'h04, 8'hec, 8'hcd, 8'h91,
    8'h4d, 8'hef, 8'haa, 8'h96, 8'hd1, 8'h6a, 8'h2c, 8'h65,
    8'h5e, 8'h8c, 8'h87, 8'h0b, 8'hcb, 8'h32, 8'h6c, 8'hb8,
    8'h67, 8'hdb, 8'h10, 8'hd6, 8'hd7, 8'ha1, 8'hf8, 8'h13,
    8'ha9, 8'h61, 8'h1c, 8'h47, 8'hd2, 8'hf2, 8'h14, 8'hc7,
    8'hf7, 8'hfd, 8'h3d, 8'h44, 8'haf, 8'h68, 8'h24, 8'ha3,
    8'h1d, 8'he2, 8'h3c, 8'h0d, 8'ha8, 8'h0c, 8'hb4, 8'h56
  };

  // Serial byte divided by (group + 1), group 0..3.
  // Divide by 3 is x*171 >> 9, exact for all 8-bit x.
  function automatic logic [7:0] key_index(input logic [7:0] s, input logic [1:0] grp);
    logic [15:0] prod;
    logic [7:0]  idx;
    prod = 16'(s) * 16'd171;
    case (grp)
      2'd0:    idx = s;
      2'd1:    idx = s >> 1;
      2'd2:    idx = {1'b0, prod[15:9]};
      2'd3:    idx = s >> 2;
      default: idx = s;
    endcase
    return idx;
  endfunction

endpackage

`default_nettype wire

@@ design/cid_decode.sv @@
// Combinational checksum, descramble and path selection for one card read.
`default_nettype none

module cid_decode
  import cid_pkg::*;
(
  input  wire logic [63:0] block_low,
  input  wire logic [63:0] block_high,
  input  wire logic [31:0] serial_number,
  output cid_result_t      result
);

  logic [15:0][7:0] raw;
  logic [3:0][7:0]  ser;
  logic [14:0][7:0] dec;
  logic [7:0]       chk_raw;
  logic [7:0]       chk_dec;
  logic             good;
  logic [15:0]      raw_uc;
  logic [31:0]      raw_id;

  assign raw = {block_high, block_low};
  assign ser = serial_number;

  always_comb begin
    logic [1:0] lane;
    logic [1:0] grp;
    chk_raw = CHK_SEED_RAW;
    chk_dec = CHK_SEED_DEC;
    lane    = 2'd0;
    grp     = 2'd0;
    for (int i = 0; i < 15; i++) begin
      lane    = 2'(i);
      grp     = 2'(i >> 2);
      chk_raw = chk_raw ^ raw[i];
      dec[i]  = raw[i] ^ KEY_ROM[key_index(ser[lane], grp)] ^ ser[2'd3 - lane];
    end
    for (int i = 0; i < 14; i++) begin
      chk_dec = chk_dec ^ dec[i];
    end
  end

  // Second check only counts when the first one passed.
  assign good   = (chk_raw == raw[15]) && (chk_dec == dec[14]);
  assign raw_uc = {raw[1], raw[0]};
  assign raw_id = {raw[5], raw[4], raw[3], raw[2]};

  always_comb begin
    if (good) begin
      result.user_code   = {dec[1], dec[0]};
      result.card_id     = {dec[5], dec[4], dec[3], dec[2]};
      result.decode_path = PATH_DESCRAMBLED;
    end else if ((raw_uc & UC_FLAG) != 16'd0) begin
      result.user_code   = (raw_uc & UC_KEEP_MASK) ^ UC_XOR;
      result.card_id     = raw_id ^ ID_XOR;
      result.decode_path = PATH_RAW_MASKED;
    end else begin
      result.user_code   = raw_uc;
      result.card_id     = raw_id;
      result.decode_path = PATH_RAW;
    end
  end

endmodule

`default_nettype wire

@@ design/card_id_descrambler.sv @@
// Card ID descrambler top level: input register, decode logic, result register.
//
// Input channel: in_valid / in_stall with block_low, block_high and
// serial_number. A transfer happens on a rising edge with in_valid high and
// in_stall low. Output channel: out_valid / out_stall with user_code,
// card_id and decode_path, same transfer rule.
// Reads pass the input register, decode logic and result register (two
// register stages). Throughput: one read per cycle unless the receiver
// stalls, set by the single decode stage between the two registers.
// Each read is independent; there is no state carried between reads.
// Reset (rst, synchronous, active high) empties both stages; no result is
// presented and in_stall drops.
// When the receiver stalls, the result register holds its value and the
// input register keeps filling; once both are full in_stall rises until
// the receiver takes a result.
`default_nettype none

module card_id_descrambler
  import cid_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [63:0] block_low,
  input  wire logic [63:0] block_high,
  input  wire logic [31:0] serial_number,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      user_code,
  output logic [31:0]      card_id,
  output logic [1:0]       decode_path
);

  logic        s1_valid;
  logic [63:0] s1_low;
  logic [63:0] s1_high;
  logic [31:0] s1_serial;
  logic        out_load;
  logic        s1_load;
  cid_result_t dec_result;
  cid_result_t result;

  assign out_load = !out_valid || !out_stall;
  assign s1_load  = !s1_valid || out_load;
  assign in_stall = !s1_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_load) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load && in_valid) begin
      s1_low    <= block_low;
      s1_high   <= block_high;
      s1_serial <= serial_number;
    end
  end

  cid_decode u_decode (
    .block_low     (s1_low),
    .block_high    (s1_high),
    .serial_number (s1_serial),
    .result        (dec_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && s1_valid) begin
      result <= dec_result;
    end
  end

  assign user_code   = result.user_code;
  assign card_id     = result.card_id;
  assign decode_path = result.decode_path;

endmodule

`default_nettype wire

@@ sim/testbench.sv @@
// Self-checking testbench for card_id_descrambler: directed and random card reads.
`timescale 1ns / 1ps

module testbench
  import cid_pkg::*;
();

  localparam int RANDOM_READS   = 650;
  localparam int WATCHDOG_LIMIT = 400;
  localparam int SETTLE_CYCLES  = 10;

  localparam logic [7:0]  RAW_SEED  = 8'hC9;
  localparam logic [7:0]  DEC_SEED  = 8'hE2;
  localparam logic [15:0] UC_MASKED = 16'h6A29;
  localparam logic [31:0] ID_MASKED = 32'h0000B2A6;

  // key bytes, entry 0 leftmost
  localparam logic [0:255][7:0] CARD_KEY = {
    128'hf4411727ab9dfae33076cc02e52a3562,
    128'hb1baeafe2f4c46d38f926d52be74e0c9,
    128'hc28e58b9e18820cedf1a51537c428400,
    128'h646b8108a43fa5a24845de7b734b1f55,
    128'hebb5c53728bf0316cf790769da0534a6,
    128'h2ef38af68360716e21dd3ee654c40650,
    128'h98bd40d9e88919c8802b115a0e85ae2d,
    128'h0f5c5b360a57ee9bc0dc771293a0221b,
    128'h098bb61ef175997f4323ede4017266fb,
    128'h316397c64abbf9299eb286c1b37094e9,
    128'hfcf07d334938cad43a785f7ef57ab7ad,
    128'h8dd839c35dd0d525ac189c3b26599a4f,
    128'h95ffbc15e76f9fb04e8290a704eccd91,
    128'h4defaa96d16a2c655e8c870bcb326cb8,
    128'h67db10d6d7a1f813a9611c47d2f214c7,
    128'hf7fd3d44af6824a31de23c0da80cb456
  };

  typedef enum {READ_CLEAN, READ_BAD_INNER, READ_BAD_OUTER, READ_NOISE} read_kind_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [63:0] block_low = '0;
  logic [63:0] block_high = '0;
  logic [31:0] serial_number = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] user_code;
  logic [31:0] card_id;
  logic [1:0]  decode_path;

  bit          calm = 1'b0;
  int unsigned quiet_cycles = 0;

  always #6 clk = ~clk;

  card_id_descrambler DUT (
    .clk, .rst, .in_valid, .in_stall, .block_low, .block_high, .serial_number,
    .out_valid, .out_stall, .user_code, .card_id, .decode_path
  );

  // XOR pad for block byte i: key entry picked by a serial byte / (group + 1),
  // then the mirrored serial byte
  function automatic logic [7:0] key_pad(input logic [31:0] ser, input int i);
    logic [7:0] sel_byte;
    logic [7:0] mix_byte;
    int         idx;
    sel_byte = ser[8*(i%4) +: 8];
    mix_byte = ser[8*(3-(i%4)) +: 8];
    idx = int'(sel_byte) / (i/4 + 1);
    return CARD_KEY[idx] ^ mix_byte;
  endfunction

  function automatic cid_result_t decode_card(input logic [63:0] lo, input logic [63:0] hi,
                                              input logic [31:0] ser);
    logic [7:0]  raw [16];
    logic [7:0]  dec [16];
    logic [7:0]  chk;
    logic [15:0] uc;
    logic [31:0] id;
    logic        good;
    cid_result_t r;
    for (int i = 0; i < 8; i++) begin
      raw[i]   = lo[8*i +: 8];
      raw[i+8] = hi[8*i +: 8];
    end
    good = 1'b0;
    chk = RAW_SEED;
    for (int i = 0; i < 15; i++) chk ^= raw[i];
    if (chk == raw[15]) begin
      for (int i = 0; i < 15; i++) dec[i] = raw[i] ^ key_pad(ser, i);
      chk = DEC_SEED;
      for (int i = 0; i < 14; i++) chk ^= dec[i];
      good = (chk == dec[14]);
    end
    if (good) begin
      r.user_code   = {dec[1], dec[0]};
      r.card_id     = {dec[5], dec[4], dec[3], dec[2]};
      r.decode_path = PATH_DESCRAMBLED;
    end else begin
      uc = {raw[1], raw[0]};
      id = {raw[5], raw[4], raw[3], raw[2]};
      r.decode_path = PATH_RAW;
      if (uc[15]) begin
        uc = {1'b0, uc[14:0]} ^ UC_MASKED;
        id = id ^ ID_MASKED;
        r.decode_path = PATH_RAW_MASKED;
      end
      r.user_code = uc;
      r.card_id   = id;
    end
    return r;
  endfunction

  class card_read_scoreboard;
    cid_result_t expected_q[$];
    int errors = 0;
    int path_count[3] = '{0, 0, 0};

    function void note_read(input logic [63:0] lo, input logic [63:0] hi,
                            input logic [31:0] ser);
      expected_q.push_back(decode_card(lo, hi, ser));
    endfunction

    function void check_result(input logic [15:0] uc, input logic [31:0] id,
                               input logic [1:0] path);
      cid_result_t exp_r;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result uc=%h id=%h path=%0d", $time, uc, id, path);
        errors++;
        return;
      end
      exp_r = expected_q.pop_front();
      if (uc !== exp_r.user_code) begin
        $display("%0t: user_code expected %h actual %h", $time, exp_r.user_code, uc);
        errors++;
      end
      if (id !== exp_r.card_id) begin
        $display("%0t: card_id expected %h actual %h", $time, exp_r.card_id, id);
        errors++;
      end
      if (path !== exp_r.decode_path) begin
        $display("%0t: decode_path expected %0d actual %0d", $time, exp_r.decode_path, path);
        errors++;
      end
      path_count[exp_r.decode_path]++;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  card_read_scoreboard sb = new();

  // Clean reads pass both checks; bad-inner passes only the first; bad-outer fails the first.
  function automatic void build_read(input read_kind_t kind, input logic [31:0] ser,
                                     output logic [63:0] lo, output logic [63:0] hi);
    logic [7:0] dec [15];
    logic [7:0] raw [16];
    logic [7:0] chk;
    if (kind == READ_NOISE) begin
      lo = {$urandom, $urandom};
      hi = {$urandom, $urandom};
      return;
    end
    chk = DEC_SEED;
    for (int i = 0; i < 14; i++) begin
      dec[i] = 8'($urandom);
      chk ^= dec[i];
    end
    dec[14] = chk;
    if (kind == READ_BAD_INNER) dec[14] ^= 8'($urandom_range(1, 255));
    chk = RAW_SEED;
    for (int i = 0; i < 15; i++) begin
      raw[i] = dec[i] ^ key_pad(ser, i);
      chk ^= raw[i];
    end
    raw[15] = chk;
    if (kind == READ_BAD_OUTER) raw[15] ^= 8'($urandom_range(1, 255));
    for (int i = 0; i < 8; i++) begin
      lo[8*i +: 8] = raw[i];
      hi[8*i +: 8] = raw[i+8];
    end
  endfunction

  function automatic logic [31:0] pick_serial();
    logic [31:0] ser;
    ser = $urandom;
    if ($urandom_range(0, 7) == 0) begin
      for (int b = 0; b < 4; b++) begin
        case ($urandom_range(0, 2))
          0: ser[8*b +: 8] = 8'h00;
          1: ser[8*b +: 8] = 8'hFF;
          default: ;
        endcase
      end
    end
    return ser;
  endfunction

  task automatic send_read(input logic [63:0] lo, input logic [63:0] hi,
                           input logic [31:0] ser);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    block_low     <= lo;
    block_high    <= hi;
    serial_number <= ser;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_read(lo, hi, ser);
  endtask

  task automatic send_kind(input read_kind_t kind, input logic [31:0] ser);
    logic [63:0] lo;
    logic [63:0] hi;
    build_read(kind, ser, lo, hi);
    send_read(lo, hi, ser);
  endtask

  // caller must be at a transfer edge with no other in_valid update pending
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // receiver: random stall before each transfer
  initial begin
    int hold;
    forever begin
      hold = calm ? 0 : $urandom_range(0, 15);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_result(user_code, card_id, decode_path);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired, %0d results outstanding", $time, sb.pending());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    logic [31:0] corner_ser [5];
    logic [31:0] ser;
    int          pick;
    read_kind_t  kind;
    corner_ser = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8080_8080, 32'h0403_0201, $urandom};
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // raw-path corners: zeros, ones, user code bit 15 set and clear
    send_read('0, '0, '0);
    send_read('1, '1, '1);
    send_read(64'h0000_0000_0000_8000, '0, 32'h1234_5678);
    send_read(64'h0000_0000_0000_7FFF, '0, 32'h8765_4321);
    send_read('1, '0, '0);
    send_read('0, '1, '1);
    foreach (corner_ser[k]) begin
      send_kind(READ_CLEAN, corner_ser[k]);
      send_kind(READ_BAD_INNER, corner_ser[k]);
      send_kind(READ_BAD_OUTER, corner_ser[k]);
    end

    for (int n = 0; n < RANDOM_READS; n++) begin
      if (n % 40 == 0) calm = ($urandom_range(0, 3) == 0);
      if (n == RANDOM_READS / 2) wait_for_results();
      pick = $urandom_range(0, 99);
      if (pick < 50)      kind = READ_CLEAN;
      else if (pick < 70) kind = READ_BAD_INNER;
      else if (pick < 85) kind = READ_BAD_OUTER;
      else                kind = READ_NOISE;
      ser = pick_serial();
      send_kind(kind, ser);
    end

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Card reads checked: %0d descrambled, %0d raw, %0d raw with bit 15 masked",
             sb.path_count[PATH_DESCRAMBLED], sb.path_count[PATH_RAW],
             sb.path_count[PATH_RAW_MASKED]);
    $display("Covered corner serials, both checks passing and failing, random idle and stall");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches, %0d results never seen", sb.errors, sb.pending());
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
